@@ design/note_tone_generator_top_defines.svh @@
// ----------------------------------------------------------------------------
// note_tone_generator_top_defines.svh
// Assertion macros used by the note tone generator core RTL.
// ----------------------------------------------------------------------------
`ifndef NOTE_TONE_GENERATOR_TOP_DEFINES_SVH
`define NOTE_TONE_GENERATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define NTG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ntg assertion failed");
// next-cycle implication
`define NTG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ntg assertion failed");
`else
`define NTG_ASSERT_NOW(label, ante, cons)
`define NTG_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ design/ntg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntg_pkg
// Types, constants and pitch ROM of the note tone generator.
// ----------------------------------------------------------------------------
package ntg_pkg;

  localparam int TONE_COUNTER_BITS_DEFAULT = 16;
  localparam int HBT_W   = 24;
  localparam int ROM_W   = 16;
  localparam int ROM_IDX_W = 5;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  localparam logic [HBT_W-1:0] HBT_RESET = 24'd92160;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_NOTE = 1'b1;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [2:0] note_degree;
    logic [1:0] octave;
    logic [7:0] half_beats;
  } ntg_item_t;

  typedef struct packed {
    logic status;
    logic note_done;
    logic tone_active;
    logic speaker_level;
  } ntg_result_t;

  function automatic logic [ROM_IDX_W-1:0] rom_index(input logic [2:0] degree,
                                                     input logic [1:0] oct);
    logic [ROM_IDX_W-1:0] oct7;
    oct7 = {oct, 3'b000} - {3'b000, oct};
    return {2'b00, degree} + oct7 - 5'd1;
  endfunction

  function automatic logic [ROM_W-1:0] pitch_rom(input logic [ROM_IDX_W-1:0] idx);
    logic [ROM_W-1:0] v;
    case (idx)
      5'd0:  v = 16'hF242;
      5'd1:  v = 16'hF3C1;
      5'd2:  v = 16'hF517;
      5'd3:  v = 16'hF5B6;
      5'd4:  v = 16'hF6D0;
      5'd5:  v = 16'hF7D1;
      5'd6:  v = 16'hF8B6;
      5'd7:  v = 16'hF921;
      5'd8:  v = 16'hF9E1;
      5'd9:  v = 16'hFA8C;
      5'd10: v = 16'hFAD8;
      5'd11: v = 16'hFB68;
      5'd12: v = 16'hFBE9;
      5'd13: v = 16'hFC5B;
      5'd14: v = 16'hFC8F;
      5'd15: v = 16'hFCEE;
      5'd16: v = 16'hFD44;
      5'd17: v = 16'hFD6B;
      5'd18: v = 16'hFDB4;
      5'd19: v = 16'hFDF4;
      5'd20: v = 16'hFE2D;
      5'd21: v = 16'hFE47;
      5'd22: v = 16'hFE77;
      5'd23: v = 16'hFEA2;
      5'd24: v = 16'hFEB6;
      5'd25: v = 16'hFEDA;
      5'd26: v = 16'hFEFA;
      default: v = 16'hFF16;
    endcase
    return v;
  endfunction

endpackage

@@ design/note_tone_generator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// note_tone_generator_top
// Buzzer note player: pitch ROM, square-wave counter and note-length timer.
// ----------------------------------------------------------------------------
// Input stream s_*: s_tuser is the mode (0 timer tick, 1 note start),
// s_tdata carries degree, octave and length. Each transaction gives exactly
// one result transaction on m_* (speaker level, tone active, note done,
// status), in order.
// Path: a transaction accepted into the input register has its result
// computed combinationally and captured in the output register, which
// drives m_tvalid and m_tdata.
// Throughput is one transaction per cycle while the output is not stalled; the
// pitch lookup and both counter updates are combinational between registers.
// cfg_*: writes half_beat_ticks, always ready; write only while idle.
// Reset: tone stopped, counters and speaker cleared, half_beat_ticks 92160.
// Stall: when m_tready is low the output register holds, then the input
// register fills and s_tready drops; no transaction is lost.
// ----------------------------------------------------------------------------
module note_tone_generator_top
  import ntg_pkg::*;
#(
  parameter int TONE_COUNTER_BITS = TONE_COUNTER_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // note_degree[2:0], octave[4:3], half_beats[12:5]
  input  logic                   s_tuser,   // mode
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // speaker_level, tone_active, note_done, status
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [HBT_W-1:0]       cfg_data
);

  ntg_item_t   item;
  ntg_result_t result;
  logic        item_valid;
  logic        can_take;
  logic        fire;

  assign cfg_ready = 1'b1;
  assign fire      = item_valid && can_take;

  ntg_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .advance    (can_take),
    .item_valid (item_valid),
    .item       (item)
  );

  ntg_core #(
    .TONE_COUNTER_BITS (TONE_COUNTER_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .item      (item),
    .result    (result)
  );

  ntg_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (item_valid),
    .result    (result),
    .can_take  (can_take),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

@@ design/ntg_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntg_in_stage
// Input register: captures one stream transaction and holds it until taken.
// ----------------------------------------------------------------------------
module ntg_in_stage
  import ntg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,   // note_degree[2:0], octave[4:3], half_beats[12:5]
  input  logic                  s_tuser,   // mode
  input  logic                  advance,
  output logic                  item_valid,
  output ntg_item_t             item
);

  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      item.mode        <= s_tuser;
      item.note_degree <= s_tdata[2:0];
      item.octave      <= s_tdata[4:3];
      item.half_beats  <= s_tdata[12:5];
    end
  end

endmodule

@@ design/ntg_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntg_core
// Tone and duration state, one item processed per cycle while fire is high.
// ----------------------------------------------------------------------------
`include "note_tone_generator_top_defines.svh"

module ntg_core
  import ntg_pkg::*;
#(
  parameter int TONE_COUNTER_BITS = TONE_COUNTER_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic [HBT_W-1:0] cfg_data,
  input  logic             fire,
  input  ntg_item_t        item,
  output ntg_result_t      result
);

  logic [HBT_W-1:0]             half_beat_ticks;
  logic [TONE_COUNTER_BITS-1:0] tone_counter, tone_counter_next;
  logic [TONE_COUNTER_BITS-1:0] reload_value, reload_value_next;
  logic                         speaker_bit, speaker_bit_next;
  logic                         running, running_next;
  logic [7:0]                   half_beats_left, half_beats_left_next;
  logic [HBT_W-1:0]             ticks_in_half_beat, ticks_in_half_beat_next;

  logic [HBT_W-1:0]                   tick_sum;
  logic [HBT_W-1:0]                   limit;
  logic [7:0]                         beats_dec;
  logic [TONE_COUNTER_BITS-1:0]       rom_reload;
  logic                               done;
  logic                               status;

  assign rom_reload = TONE_COUNTER_BITS'(pitch_rom(rom_index(item.note_degree,
                                                             item.octave)));
  assign tick_sum   = ticks_in_half_beat + 1'b1;
  assign limit      = (half_beat_ticks == '0) ? HBT_W'(1) : half_beat_ticks;
  assign beats_dec  = half_beats_left - 8'd1;

  always_comb begin
    tone_counter_next       = tone_counter;
    reload_value_next       = reload_value;
    speaker_bit_next        = speaker_bit;
    running_next            = running;
    half_beats_left_next    = half_beats_left;
    ticks_in_half_beat_next = ticks_in_half_beat;
    done                    = 1'b0;
    status                  = STATUS_OK;
    if (item.mode == MODE_NOTE) begin
      if (item.half_beats == 8'd0) begin
        running_next            = 1'b0;
        half_beats_left_next    = 8'd0;
        ticks_in_half_beat_next = '0;
      end else if (item.note_degree == 3'd0) begin
        status = STATUS_REJECT;
      end else begin
        reload_value_next       = rom_reload;
        tone_counter_next       = rom_reload;
        running_next            = 1'b1;
        half_beats_left_next    = item.half_beats;
        ticks_in_half_beat_next = '0;
      end
    end else if (running) begin
      if (tone_counter == '1) begin
        speaker_bit_next  = ~speaker_bit;
        tone_counter_next = reload_value;
      end else begin
        tone_counter_next = tone_counter + 1'b1;
      end
      if (tick_sum >= limit || tick_sum == '0) begin
        ticks_in_half_beat_next = '0;
        half_beats_left_next    = beats_dec;
        if (beats_dec == 8'd0) begin
          running_next = 1'b0;
          done         = 1'b1;
        end
      end else begin
        ticks_in_half_beat_next = tick_sum;
      end
    end
  end

  always_comb begin
    result.speaker_level = speaker_bit_next;
    result.tone_active   = running_next;
    result.note_done     = done;
    result.status        = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_beat_ticks    <= HBT_RESET;
      tone_counter       <= '0;
      reload_value       <= '0;
      speaker_bit        <= 1'b0;
      running            <= 1'b0;
      half_beats_left    <= 8'd0;
      ticks_in_half_beat <= '0;
    end else begin
      if (cfg_valid) begin
        half_beat_ticks <= cfg_data;
      end
      if (fire) begin
        tone_counter       <= tone_counter_next;
        reload_value       <= reload_value_next;
        speaker_bit        <= speaker_bit_next;
        running            <= running_next;
        half_beats_left    <= half_beats_left_next;
        ticks_in_half_beat <= ticks_in_half_beat_next;
      end
    end
  end

  `NTG_ASSERT_NEXT(a_done_stops, fire && result.note_done, !running)
  `NTG_ASSERT_NOW(a_tick_no_status, fire && item.mode == MODE_TICK, result.status == STATUS_OK)
  `NTG_ASSERT_NOW(a_note_no_done, fire && item.mode == MODE_NOTE, !result.note_done)
  `NTG_ASSERT_NEXT(a_idle_holds, !fire, $stable(tone_counter) && $stable(speaker_bit))
  `NTG_ASSERT_NEXT(a_reject_holds, fire && result.status == STATUS_REJECT, $stable(reload_value) && $stable(running))

endmodule

@@ design/ntg_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntg_out_stage
// Result register driving the master stream side.
// ----------------------------------------------------------------------------
module ntg_out_stage
  import ntg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   res_valid,
  input  ntg_result_t            result,
  output logic                   can_take,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata   // speaker_level, tone_active, note_done, status
);

  ntg_result_t held;

  assign can_take = !m_tvalid || m_tready;
  assign m_tdata  = {4'b0000, held};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (can_take) begin
      m_tvalid <= res_valid;
    end
    if (can_take && res_valid) begin
      held <= result;
    end
  end

endmodule
